@@ design/packet_route_relay_filter_unit_macros.svh @@
// Assertion macros for the packet route relay filter.
// Depends on nothing; the including module must have clk and arst_n in scope.
`ifndef PACKET_ROUTE_RELAY_FILTER_UNIT_MACROS_SVH
`define PACKET_ROUTE_RELAY_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRRF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/prrf_pkg.sv @@
// Package for the packet route relay filter: codes, route constants and the
// packet checksum function. Depends on nothing.
`timescale 1ns / 1ps

package prrf_pkg;

	typedef logic [1:0] action_t;

	localparam action_t ACT_DROP    = 2'd0;
	localparam action_t ACT_DELIVER = 2'd1;
	localparam action_t ACT_REBCAST = 2'd2;
	localparam action_t ACT_FORWARD = 2'd3;

	localparam logic [7:0] KIND_BEACON = 8'd0;
	localparam logic [7:0] KIND_DATA   = 8'd1;

	localparam logic [15:0] NO_ROUTE_ADDR = 16'hFFFF;
	localparam logic [7:0]  NO_ROUTE_HOPS = 8'hFF;

	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] CFG_IS_SINK = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_NODE_ID = 1'd1;

	// XOR checksum over type, sequence, hops and both light bytes.
	function automatic logic [7:0] xsum(input logic [7:0] kind, input logic [7:0] seq,
			input logic [7:0] hops, input logic [15:0] light);
		return kind ^ seq ^ hops ^ light[7:0] ^ light[15:8];
	endfunction

endpackage

@@ design/packet_route_relay_filter_unit.sv @@
// A packet is captured on its accepting edge, evaluated, then committed to the result register;
// a data packet that needs a search walks the seen ring in between, and an early hit ends it.
// A new packet is taken only once the last one is committed: the one comparator walks the ring
// an entry a cycle, and a waiting result stalls the commit.
// Reset (arst_n, asynchronous, active low) clears the seen valid bits, insert pointer and route,
// and selects the sink role with node id zero. Depends on prrf_pkg and the macro header.
`timescale 1ns / 1ps
`include "packet_route_relay_filter_unit_macros.svh"

module packet_route_relay_filter_unit import prrf_pkg::*; #(
	parameter int SEEN_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [15:0]           cfg_wdata,
	// Received packet channel.
	input  logic                  pkt_valid,
	output logic                  pkt_ready,
	input  logic [7:0]            pkt_kind,
	input  logic [15:0]           src_addr,
	input  logic [7:0]            seq_no,
	input  logic [7:0]            hops,
	input  logic [15:0]           light_level,
	input  logic [15:0]           dest_addr,
	input  logic [7:0]            check_byte,
	// Result channel.
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [1:0]            action,
	output logic [7:0]            out_kind,
	output logic [15:0]           out_src,
	output logic [7:0]            out_seq,
	output logic [7:0]            out_hops,
	output logic [15:0]           out_light,
	output logic [15:0]           out_dest,
	output logic [7:0]            out_check,
	output logic [15:0]           route_next,
	output logic [7:0]            route_hops
);

	// Ring index width, and a scan counter wide enough to hold the depth itself.
	localparam int IDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam int CNT_W = $clog2(SEEN_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEEN_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SEEN_DEPTH);

	// Sequencer: capture the packet, decide whether a ring search is needed,
	// walk the ring, then commit the result and any state update.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;

	// Configuration registers.
	logic        is_sink_q;
	logic [15:0] node_id_q;

	// Captured packet.
	logic [7:0]  kind_q;
	logic [15:0] src_q;
	logic [7:0]  seq_q;
	logic [7:0]  hops_q;
	logic [15:0] light_q;
	logic [15:0] dest_q;
	logic [7:0]  chk_q;
	logic        dup_q;

	// Route state.
	logic [15:0] next_hop_q;
	logic [7:0]  hop_dist_q;

	// Seen ring: the pairs live in a memory, validity in flip-flops.
	logic [23:0]           seen_mem [SEEN_DEPTH];
	logic [SEEN_DEPTH-1:0] seen_vld_q;
	logic [IDX_W-1:0]      ins_ptr_q;

	// Scan pipeline: a read is issued at scan_idx_q, and the registered word is
	// compared with the captured pair in the following cycle.
	logic [CNT_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic             cmp_vld_q;
	logic [23:0]      rd_q;

	// Result register.
	logic        res_valid_q;
	action_t     act_q;
	logic [7:0]  o_kind_q;
	logic [15:0] o_src_q;
	logic [7:0]  o_seq_q;
	logic [7:0]  o_hops_q;
	logic [15:0] o_light_q;
	logic [15:0] o_dest_q;
	logic [7:0]  o_chk_q;
	logic [15:0] o_rnext_q;
	logic [7:0]  o_rhops_q;

	logic        pkt_acc;
	logic        out_free;
	logic        fin_go;
	logic        chk_ok;
	logic        is_beacon;
	logic        is_data;
	logic        dest_me;
	logic        need_scan;
	logic        rd_issue;
	logic        hit;
	logic        better;
	logic [7:0]  new_dist;
	logic [15:0] new_next;
	logic        ins_en;
	action_t     act_d;
	logic [15:0] o_src_d;
	logic [7:0]  o_hops_d;
	logic [15:0] o_dest_d;
	logic [7:0]  o_chk_d;

	assign pkt_ready = (state_q == ST_IDLE);
	assign pkt_acc   = pkt_valid && pkt_ready;
	// The result register may be refilled when empty or being emptied this cycle.
	assign out_free  = !res_valid_q || res_ready;
	assign fin_go    = (state_q == ST_FIN) && out_free;

	// Classification of the captured packet; an item with a bad checksum is
	// neither a beacon nor data.
	assign chk_ok    = (chk_q == xsum(kind_q, seq_q, hops_q, light_q));
	assign is_beacon = chk_ok && (kind_q == KIND_BEACON);
	assign is_data   = chk_ok && (kind_q == KIND_DATA);
	assign dest_me   = (dest_q == node_id_q);
	// A relay only searches the ring for data addressed to it.
	assign need_scan = is_data && (is_sink_q || dest_me);

	assign rd_issue = (state_q == ST_SCAN) && (scan_idx_q < DEPTH_CNT);
	assign hit      = cmp_vld_q && seen_vld_q[cmp_idx_q] && (rd_q == {src_q, seq_q});

	// A beacon with 255 hops cannot improve the route, so the add is nine bits wide.
	assign better   = ({1'b0, hops_q} + 9'd1) < {1'b0, hop_dist_q};
	assign new_dist = (is_beacon && better) ? (hops_q + 8'd1) : hop_dist_q;
	assign new_next = (is_beacon && better) ? src_q : next_hop_q;

	// A new pair goes into the ring whenever the search found no copy of it.
	assign ins_en = need_scan && !dup_q;

	always_comb begin
		act_d    = ACT_DROP;
		o_src_d  = src_q;
		o_hops_d = hops_q;
		o_dest_d = dest_q;
		o_chk_d  = chk_q;
		if (is_beacon) begin
			if (!is_sink_q) begin
				act_d    = ACT_REBCAST;
				o_src_d  = node_id_q;
				o_hops_d = new_dist;
				o_chk_d  = xsum(kind_q, seq_q, new_dist, light_q);
			end
		end else if (is_data && !dup_q) begin
			if (is_sink_q) begin
				act_d = ACT_DELIVER;
			end else if (dest_me) begin
				act_d    = ACT_FORWARD;
				o_hops_d = hop_dist_q;
				o_dest_d = next_hop_q;
				o_chk_d  = xsum(kind_q, seq_q, hop_dist_q, light_q);
			end
		end
	end

	// Configuration; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_sink_q <= 1'b1;
			node_id_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_IS_SINK: is_sink_q <= cfg_wdata[0];
				CFG_NODE_ID: node_id_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Captured packet fields carry no reset.
	always_ff @(posedge clk) begin
		if (pkt_acc) begin
			kind_q  <= pkt_kind;
			src_q   <= src_addr;
			seq_q   <= seq_no;
			hops_q  <= hops;
			light_q <= light_level;
			dest_q  <= dest_addr;
			chk_q   <= check_byte;
		end
	end

	// Ring memory: one read port for the scan, one write port for insertion.
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_q <= seen_mem[scan_idx_q[IDX_W-1:0]];
		end
		if (fin_go && ins_en) begin
			seen_mem[ins_ptr_q] <= {src_q, seq_q};
		end
	end

	// Sequencer, scan control, route and ring bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dup_q      <= 1'b0;
			scan_idx_q <= '0;
			cmp_idx_q  <= '0;
			cmp_vld_q  <= 1'b0;
			seen_vld_q <= '0;
			ins_ptr_q  <= '0;
			next_hop_q <= NO_ROUTE_ADDR;
			hop_dist_q <= NO_ROUTE_HOPS;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pkt_acc) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					dup_q      <= 1'b0;
					scan_idx_q <= '0;
					cmp_vld_q  <= 1'b0;
					state_q    <= need_scan ? ST_SCAN : ST_FIN;
				end
				ST_SCAN: begin
					cmp_vld_q <= rd_issue;
					cmp_idx_q <= scan_idx_q[IDX_W-1:0];
					if (rd_issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
					if (hit) begin
						dup_q   <= 1'b1;
						state_q <= ST_FIN;
					end else if (cmp_vld_q && (cmp_idx_q == LAST_IDX)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q    <= ST_IDLE;
						next_hop_q <= new_next;
						hop_dist_q <= new_dist;
						if (ins_en) begin
							seen_vld_q[ins_ptr_q] <= 1'b1;
							ins_ptr_q <= (ins_ptr_q == LAST_IDX) ? '0 : (ins_ptr_q + 1'b1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_go) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload; packet fields read zero on a drop.
	always_ff @(posedge clk) begin
		if (fin_go) begin
			act_q     <= act_d;
			o_kind_q  <= (act_d == ACT_DROP) ? 8'd0  : kind_q;
			o_src_q   <= (act_d == ACT_DROP) ? 16'd0 : o_src_d;
			o_seq_q   <= (act_d == ACT_DROP) ? 8'd0  : seq_q;
			o_hops_q  <= (act_d == ACT_DROP) ? 8'd0  : o_hops_d;
			o_light_q <= (act_d == ACT_DROP) ? 16'd0 : light_q;
			o_dest_q  <= (act_d == ACT_DROP) ? 16'd0 : o_dest_d;
			o_chk_q   <= (act_d == ACT_DROP) ? 8'd0  : o_chk_d;
			o_rnext_q <= new_next;
			o_rhops_q <= new_dist;
		end
	end

	assign res_valid  = res_valid_q;
	assign action     = act_q;
	assign out_kind   = o_kind_q;
	assign out_src    = o_src_q;
	assign out_seq    = o_seq_q;
	assign out_hops   = o_hops_q;
	assign out_light  = o_light_q;
	assign out_dest   = o_dest_q;
	assign out_check  = o_chk_q;
	assign route_next = o_rnext_q;
	assign route_hops = o_rhops_q;

	// The learned hop distance can only shrink.
	`PRRF_ASSERT_NEXT(a_route_shrinks, 1'b1, hop_dist_q <= $past(hop_dist_q), "hop distance grew")
	// A duplicate found by the search is never written back into the ring.
	`PRRF_ASSERT_IMPL(a_dup_no_insert, (state_q == ST_FIN) && dup_q, !ins_en, "duplicate inserted")
	// Every ring insertion is reported as a delivery or a forward.
	`PRRF_ASSERT_NEXT(a_insert_reported, fin_go && ins_en,
		res_valid_q && ((act_q == ACT_DELIVER) || (act_q == ACT_FORWARD)),
		"ring insert without delivery")
	// The scan never reads past the end of the ring.
	`PRRF_ASSERT_IMPL(a_scan_bound, state_q == ST_SCAN, scan_idx_q <= DEPTH_CNT,
		"scan index overran the ring")

endmodule
